// ===== hdl/pcbd_pkg.sv =====
// Package with widths, codes and types shared by the pulse-count backlight dimmer.
package pcbd_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int CHIP_STEPS_DEF  = 32;

  localparam int LEVEL_W    = 8;
  localparam int STEP_W     = 6;
  localparam int PULSE_W    = 5;
  localparam int INDEX_W    = 4;
  localparam int TSIZE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int ENTRY_W    = LEVEL_W + STEP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd2;

  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_EMIT
  } pcbd_state_t;

  typedef enum logic {
    RK_STATUS,
    RK_STEP
  } pcbd_kind_t;

endpackage

// ===== hdl/pcbd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pcbd_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/pulse_count_backlight_dimmer_unit.sv =====
// Top level of the pulse-count backlight dimmer with its threshold table sequencer.
//
// A table write, a skipped request or a request whose level is zero goes from the idle state
// straight to the emit state. A nonzero brightness request walks the threshold table one entry per
// cycle through the single read port of the table RAM, passing the first state and, for a table of
// more than one entry, the scan state before the emit state. One transaction is in work at a time;
// the output register holds a finished result while the next input is accepted.
module pulse_count_backlight_dimmer_unit #(
  parameter int TABLE_DEPTH = pcbd_pkg::TABLE_DEPTH_DEF,
  parameter int CHIP_STEPS  = pcbd_pkg::CHIP_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [pcbd_pkg::LEVEL_W-1:0]     in_level,
  input  logic                             in_power_unblanked,
  input  logic                             in_display_unblanked,
  input  logic [pcbd_pkg::INDEX_W-1:0]     in_entry_index,
  input  logic [pcbd_pkg::LEVEL_W-1:0]     in_entry_threshold,
  input  logic [pcbd_pkg::STEP_W-1:0]      in_entry_step,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pcbd_pkg::PULSE_W-1:0]     out_pulse_count,
  output logic                             out_chip_power_up,
  output logic                             out_control_line,
  output logic                             out_drive_enable,
  output logic [pcbd_pkg::STEP_W-1:0]      out_chosen_step,
  output logic                             out_is_dimming,
  output logic                             out_skipped
);
  import pcbd_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CS_W = 7;
  localparam int SUM_W = 8;
  localparam logic [CS_W-1:0]  CS_VAL  = CS_W'(CHIP_STEPS);
  localparam logic [SUM_W-1:0] CS_SUM  = SUM_W'(CHIP_STEPS);
  localparam logic [8:0]       TD_VAL  = 9'(TABLE_DEPTH);

  pcbd_state_t state_r, state_nxt;
  pcbd_kind_t  kind_r, kind_nxt;

  logic [TSIZE_W-1:0] table_size_r;
  logic [LEVEL_W-1:0] min_bright_r;
  logic               enabled_r;

  logic [STEP_W-1:0]  prev_step_r, prev_step_nxt;
  logic [LEVEL_W-1:0] cur_level_r, cur_level_nxt;

  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic               skip_r, skip_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [LEVEL_W-1:0] thr_prev_r, thr_prev_nxt;
  logic [STEP_W-1:0]  stp_prev_r, stp_prev_nxt;
  logic [TSIZE_W-1:0] scan_idx_r, scan_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PULSE_W-1:0] out_pulse_r, out_pulse_nxt;
  logic               out_pwr_r, out_pwr_nxt;
  logic               out_line_r, out_line_nxt;
  logic               out_drive_r, out_drive_nxt;
  logic [STEP_W-1:0]  out_step_r, out_step_nxt;
  logic               out_dim_r, out_dim_nxt;
  logic               out_skip_r, out_skip_nxt;

  logic               in_acc;
  logic               out_free;
  logic [TSIZE_W-1:0] ts_eff;
  logic [TSIZE_W-1:0] n_last;
  logic [LEVEL_W-1:0] lvl_eff;
  logic               req_skip;
  logic               wr_en;
  logic [STEP_W-1:0]  wr_step;
  logic [ENTRY_W-1:0] rd_data;
  logic [LEVEL_W-1:0] rd_thr;
  logic [STEP_W-1:0]  rd_stp;
  logic               scan_hit;
  logic               scan_end;
  logic [CS_W-1:0]    prev_eff;
  logic [SUM_W-1:0]   pulse_sum;
  logic [SUM_W-1:0]   pulse_mod;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (table_size_r == '0) begin
      ts_eff = TSIZE_W'(1);
    end else if ({4'b0, table_size_r} > TD_VAL) begin
      ts_eff = TSIZE_W'(TABLE_DEPTH);
    end else begin
      ts_eff = table_size_r;
    end
  end
  assign n_last = ts_eff - TSIZE_W'(1);

  assign lvl_eff  = (in_power_unblanked && in_display_unblanked) ? in_level : '0;
  assign req_skip = !enabled_r && (cur_level_r == '0);

  assign wr_en   = in_acc && (in_opcode == OP_WRITE) && ({5'b0, in_entry_index} < TD_VAL);
  assign wr_step = ({1'b0, in_entry_step} > CS_VAL) ? STEP_W'(CHIP_STEPS) : in_entry_step;

  pcbd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(in_entry_index)),
    .wdata({in_entry_threshold, wr_step}),
    .raddr(AW'(scan_idx_nxt)),
    .rdata(rd_data)
  );

  assign rd_thr   = rd_data[ENTRY_W-1:STEP_W];
  assign rd_stp   = rd_data[STEP_W-1:0];
  assign scan_hit = (lvl_r <= thr_prev_r) && (lvl_r > rd_thr);
  assign scan_end = (scan_idx_r == n_last);

  assign prev_eff  = (prev_step_r == '0) ? CS_VAL : {1'b0, prev_step_r};
  assign pulse_sum = SUM_W'(step_r) + CS_SUM - SUM_W'(prev_eff);
  assign pulse_mod = (pulse_sum >= CS_SUM) ? (pulse_sum - CS_SUM) : pulse_sum;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_WRITE || req_skip || lvl_eff == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        state_nxt = (n_last == '0) ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    lvl_nxt       = lvl_r;
    skip_nxt      = skip_r;
    step_nxt      = step_r;
    thr_prev_nxt  = thr_prev_r;
    stp_prev_nxt  = stp_prev_r;
    scan_idx_nxt  = scan_idx_r;
    prev_step_nxt = prev_step_r;
    cur_level_nxt = cur_level_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pulse_nxt = out_pulse_r;
    out_pwr_nxt   = out_pwr_r;
    out_line_nxt  = out_line_r;
    out_drive_nxt = out_drive_r;
    out_step_nxt  = out_step_r;
    out_dim_nxt   = out_dim_r;
    out_skip_nxt  = out_skip_r;
    unique case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        if (in_acc) begin
          lvl_nxt  = lvl_eff;
          step_nxt = '0;
          skip_nxt = (in_opcode == OP_LEVEL) && req_skip;
          kind_nxt = (in_opcode == OP_WRITE || req_skip) ? RK_STATUS : RK_STEP;
        end
      end
      ST_FIRST: begin
        if (n_last == '0) begin
          step_nxt = rd_stp;
        end else begin
          thr_prev_nxt = rd_thr;
          stp_prev_nxt = rd_stp;
          scan_idx_nxt = TSIZE_W'(1);
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          step_nxt = stp_prev_r;
        end else if (scan_end) begin
          step_nxt = rd_stp;
        end else begin
          thr_prev_nxt = rd_thr;
          stp_prev_nxt = rd_stp;
          scan_idx_nxt = scan_idx_r + TSIZE_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_skip_nxt  = skip_r;
          if (kind_r == RK_STATUS) begin
            out_pulse_nxt = '0;
            out_pwr_nxt   = 1'b0;
            out_line_nxt  = (prev_step_r != '0);
            out_drive_nxt = (prev_step_r != '0);
            out_step_nxt  = prev_step_r;
            out_dim_nxt   = (cur_level_r <= min_bright_r);
          end else begin
            cur_level_nxt = lvl_r;
            prev_step_nxt = step_r;
            out_dim_nxt   = (lvl_r <= min_bright_r);
            out_step_nxt  = step_r;
            if (step_r == '0) begin
              out_pulse_nxt = '0;
              out_pwr_nxt   = 1'b0;
              out_line_nxt  = 1'b0;
              out_drive_nxt = 1'b0;
            end else begin
              out_pulse_nxt = PULSE_W'(pulse_mod);
              out_pwr_nxt   = (prev_step_r == '0);
              out_line_nxt  = 1'b1;
              out_drive_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        scan_idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      prev_step_r  <= '0;
      cur_level_r  <= '0;
      table_size_r <= TSIZE_W'(1);
      min_bright_r <= '0;
      enabled_r    <= 1'b1;
      scan_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_step_r <= prev_step_nxt;
      cur_level_r <= cur_level_nxt;
      scan_idx_r  <= scan_idx_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TABLE_SIZE: table_size_r <= cfg_data[TSIZE_W-1:0];
          CFG_MIN_BRIGHT: min_bright_r <= cfg_data[LEVEL_W-1:0];
          CFG_ENABLED:    enabled_r    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    lvl_r       <= lvl_nxt;
    skip_r      <= skip_nxt;
    step_r      <= step_nxt;
    thr_prev_r  <= thr_prev_nxt;
    stp_prev_r  <= stp_prev_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_pwr_r   <= out_pwr_nxt;
    out_line_r  <= out_line_nxt;
    out_drive_r <= out_drive_nxt;
    out_step_r  <= out_step_nxt;
    out_dim_r   <= out_dim_nxt;
    out_skip_r  <= out_skip_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pulse_count   = out_pulse_r;
  assign out_chip_power_up = out_pwr_r;
  assign out_control_line  = out_line_r;
  assign out_drive_enable  = out_drive_r;
  assign out_chosen_step   = out_step_r;
  assign out_is_dimming    = out_dim_r;
  assign out_skipped       = out_skip_r;

  a_pulses_need_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pulse_r != '0 |-> out_line_r)
    else $error("pulses reported with the control line low");

  a_power_up_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pwr_r |-> out_step_r != '0 && !out_skip_r)
    else $error("power-up reported without a nonzero step");

  a_prev_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, prev_step_r} <= CS_VAL)
    else $error("previous step above the chip step count");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_idx_r <= n_last && scan_idx_r != '0)
    else $error("table scan left the valid entries");

endmodule
